// ===== sv/tats_pkg.sv =====
// Package for the token announce track sequencer.
// Holds field widths, track codes, the control word types and the microcode ROM.
// No dependencies.
package tats_pkg;

   // Field widths
   localparam int TOKEN_W  = 32;
   localparam int FOLDER_W = 2;
   localparam int TRACK_W  = 8;
   localparam int LIMIT_W  = 8;
   localparam int VAL_W    = 31;
   localparam int PROD_W   = 63;
   localparam int Q_LSB    = 35;
   localparam int Q_W      = PROD_W - Q_LSB;
   localparam int DIGIT_W  = 4;
   localparam int PC_W     = 4;

   // Reciprocal of ten, scaled by 2**35
   localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

   localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd99;

   // Track codes
   localparam logic [FOLDER_W-1:0] FOLDER_FRAME = 2'd1;
   localparam logic [FOLDER_W-1:0] FOLDER_WHOLE = 2'd2;
   localparam logic [FOLDER_W-1:0] FOLDER_DIGIT = 2'd3;
   localparam logic [TRACK_W-1:0]  TRACK_PREFIX = 8'd1;
   localparam logic [TRACK_W-1:0]  TRACK_SUFFIX = 8'd2;
   localparam logic [TRACK_W-1:0]  TRACK_ZERO   = 8'd1;

   // Program addresses
   localparam logic [PC_W-1:0] ST_LOAD   = 4'd0;
   localparam logic [PC_W-1:0] ST_PREFIX = 4'd1;
   localparam logic [PC_W-1:0] ST_ZCHK   = 4'd2;
   localparam logic [PC_W-1:0] ST_MUL    = 4'd3;
   localparam logic [PC_W-1:0] ST_DIV    = 4'd4;
   localparam logic [PC_W-1:0] ST_DIGIT  = 4'd5;
   localparam logic [PC_W-1:0] ST_SUFFIX = 4'd6;
   localparam logic [PC_W-1:0] ST_WHOLE  = 4'd7;
   localparam logic [PC_W-1:0] ST_ZERO   = 4'd8;
   localparam logic [PC_W-1:0] PROG_LEN  = 4'd9;

   typedef enum logic [2:0] {
      DP_NOP  = 3'd0,
      DP_LOAD = 3'd1,
      DP_MUL  = 3'd2,
      DP_DIV  = 3'd3,
      DP_POP  = 3'd4
   } dp_op_type;

   typedef enum logic [2:0] {
      EM_NONE   = 3'd0,
      EM_PREFIX = 3'd1,
      EM_WHOLE  = 3'd2,
      EM_ZERO   = 3'd3,
      EM_DIGIT  = 3'd4,
      EM_SUFFIX = 3'd5
   } emit_type;

   typedef enum logic [1:0] {
      HOLD_NONE = 2'd0,
      HOLD_REQ  = 2'd1,
      HOLD_RSP  = 2'd2
   } hold_type;

   typedef enum logic [2:0] {
      BR_NEVER    = 3'd0,
      BR_ALWAYS   = 3'd1,
      BR_NEG      = 3'd2,
      BR_DIRECT   = 3'd3,
      BR_ZERO     = 3'd4,
      BR_MORE     = 3'd5,
      BR_DIG_LEFT = 3'd6
   } br_type;

   // One microcode word
   typedef struct packed {
      dp_op_type       dp_op;
      emit_type        emit;
      hold_type        hold_on;
      br_type          br_cond;
      logic [PC_W-1:0] target;
   } tats_step_type;

   // Sequencer to datapath
   typedef struct packed {
      tats_step_type step;
      logic          go;
   } tats_ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic neg;
      logic direct;
      logic zero;
      logic more;
      logic dig_left;
      logic rsp_free;
   } tats_stat_type;

   // Microcode ROM
   function automatic tats_step_type tats_ucode(input logic [PC_W-1:0] addr);
      tats_step_type w;
      unique case (addr)
         ST_LOAD:   w = '{DP_LOAD, EM_NONE,   HOLD_REQ,  BR_NEG,      ST_LOAD};
         ST_PREFIX: w = '{DP_NOP,  EM_PREFIX, HOLD_RSP,  BR_DIRECT,   ST_WHOLE};
         ST_ZCHK:   w = '{DP_NOP,  EM_NONE,   HOLD_NONE, BR_ZERO,     ST_ZERO};
         ST_MUL:    w = '{DP_MUL,  EM_NONE,   HOLD_NONE, BR_NEVER,    ST_LOAD};
         ST_DIV:    w = '{DP_DIV,  EM_NONE,   HOLD_NONE, BR_MORE,     ST_MUL};
         ST_DIGIT:  w = '{DP_POP,  EM_DIGIT,  HOLD_RSP,  BR_DIG_LEFT, ST_DIGIT};
         ST_SUFFIX: w = '{DP_NOP,  EM_SUFFIX, HOLD_RSP,  BR_ALWAYS,   ST_LOAD};
         ST_WHOLE:  w = '{DP_NOP,  EM_WHOLE,  HOLD_RSP,  BR_ALWAYS,   ST_SUFFIX};
         ST_ZERO:   w = '{DP_NOP,  EM_ZERO,   HOLD_RSP,  BR_ALWAYS,   ST_SUFFIX};
         default:   w = '{DP_NOP,  EM_NONE,   HOLD_NONE, BR_ALWAYS,   ST_LOAD};
      endcase
      return w;
   endfunction

endpackage

// ===== sv/tats_ifs.sv =====
// Channel interfaces of the token announce track sequencer.
// Request, response and register-write channels; depends on tats_pkg.
interface tats_req_if import tats_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [TOKEN_W-1:0] token;
   modport source (output valid, output token, input ready);
   modport sink (input valid, input token, output ready);
endinterface

interface tats_rsp_if import tats_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FOLDER_W-1:0] folder;
   logic [TRACK_W-1:0]  track;
   logic                last;
   modport source (output valid, output folder, output track, output last, input ready);
   modport sink (input valid, input folder, input track, input last, output ready);
endinterface

interface tats_csr_if import tats_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] direct_limit;
   modport source (output valid, output direct_limit, input ready);
   modport sink (input valid, input direct_limit, output ready);
endinterface

// ===== sv/tats_datapath.sv =====
// Datapath of the token announce track sequencer: value register, divide-by-ten
// step, digit stack, limit register and response register. Depends on tats_pkg.
module tats_datapath import tats_pkg::*; #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tats_ctrl_type             ctrl,
   output tats_stat_type             stat,
   input  logic signed [TOKEN_W-1:0] req_token,
   input  logic                      csr_valid,
   input  logic [LIMIT_W-1:0]        csr_direct_limit,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FOLDER_W-1:0]       rsp_folder,
   output logic [TRACK_W-1:0]        rsp_track,
   output logic                      rsp_last
);

   localparam int NDW = $clog2(MAX_DIGITS + 1);
   localparam int IW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   logic [LIMIT_W-1:0]  limit_ff;
   logic [VAL_W-1:0]    v_ff, v_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [NDW-1:0]      ndig_ff, ndig_in;
   logic [DIGIT_W-1:0]  stack_ff [MAX_DIGITS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [FOLDER_W-1:0] folder_ff, folder_in;
   logic [TRACK_W-1:0]  track_ff, track_in;
   logic                last_ff, last_in;

   logic [Q_W-1:0]      quot;
   logic [VAL_W-1:0]    quot10;
   logic [DIGIT_W-1:0]  rem;
   logic [IW-1:0]       wr_idx, rd_idx;
   logic [NDW-1:0]      ndig_dec;
   logic                emit_go;

   // Quotient and remainder from the registered reciprocal product
   assign quot     = prod_ff[PROD_W-1:Q_LSB];
   assign quot10   = VAL_W'({quot, 3'b000}) + VAL_W'({quot, 1'b0});
   assign rem      = DIGIT_W'(v_ff - quot10);
   assign ndig_dec = ndig_ff - NDW'(1);
   assign wr_idx   = ndig_ff[IW-1:0];
   assign rd_idx   = ndig_dec[IW-1:0];

   // Status for branch decisions
   assign stat.neg      = req_token[TOKEN_W-1];
   assign stat.direct   = (v_ff != '0) && (v_ff <= VAL_W'(limit_ff));
   assign stat.zero     = (v_ff == '0);
   assign stat.more     = (quot != '0) && (ndig_ff != NDW'(MAX_DIGITS - 1));
   assign stat.dig_left = (ndig_ff != NDW'(1));
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // Value and digit count
   always_comb begin
      v_in    = v_ff;
      ndig_in = ndig_ff;
      if (ctrl.go) begin
         unique case (ctrl.step.dp_op)
            DP_LOAD: begin
               v_in    = req_token[VAL_W-1:0];
               ndig_in = '0;
            end
            DP_DIV: begin
               v_in    = VAL_W'(quot);
               ndig_in = ndig_ff + NDW'(1);
            end
            DP_POP: ndig_in = ndig_dec;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (ctrl.go && ctrl.step.dp_op == DP_MUL) begin
         prod_ff <= PROD_W'(v_ff) * PROD_W'(RECIP10);
      end
      if (ctrl.go && ctrl.step.dp_op == DP_DIV) begin
         stack_ff[wr_idx] <= rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff  <= '0;
         limit_ff <= LIMIT_RST;
      end else begin
         ndig_ff <= ndig_in;
         if (csr_valid) begin
            limit_ff <= csr_direct_limit;
         end
      end
   end

   // Response register: load a track, drop it when taken
   assign emit_go = ctrl.go && (ctrl.step.emit != EM_NONE);

   always_comb begin
      folder_in    = folder_ff;
      track_in     = track_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         last_in      = 1'b0;
         unique case (ctrl.step.emit)
            EM_PREFIX: begin
               folder_in = FOLDER_FRAME;
               track_in  = TRACK_PREFIX;
            end
            EM_WHOLE: begin
               folder_in = FOLDER_WHOLE;
               track_in  = v_ff[TRACK_W-1:0];
            end
            EM_ZERO: begin
               folder_in = FOLDER_DIGIT;
               track_in  = TRACK_ZERO;
            end
            EM_DIGIT: begin
               folder_in = FOLDER_DIGIT;
               track_in  = TRACK_W'(stack_ff[rd_idx]) + TRACK_W'(1);
            end
            EM_SUFFIX: begin
               folder_in = FOLDER_FRAME;
               track_in  = TRACK_SUFFIX;
               last_in   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      folder_ff <= folder_in;
      track_ff  <= track_in;
      last_ff   <= last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_folder = folder_ff;
   assign rsp_track  = track_ff;
   assign rsp_last   = last_ff;

`ifndef SYNTH
   a_ndig_range: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= NDW'(MAX_DIGITS))
      else $error("digit count beyond stack depth");

   a_div_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.go && ctrl.step.dp_op == DP_DIV |=> v_ff < $past(v_ff))
      else $error("divide step did not reduce the value");

   a_last_is_suffix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && last_ff |-> folder_ff == FOLDER_FRAME && track_ff == TRACK_SUFFIX)
      else $error("last mark on a track other than the suffix");
`endif

endmodule

// ===== sv/tats_sequencer.sv =====
// Microcode sequencer of the token announce track sequencer: step counter,
// ROM lookup, stall and conditional jump. Depends on tats_pkg.
module tats_sequencer import tats_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  tats_stat_type stat,
   input  logic          req_valid,
   output logic          req_ready,
   output tats_ctrl_type ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   tats_step_type   step;
   logic            stall;
   logic            taken;

   assign step = tats_ucode(pc_ff);

   // Hold the step while its channel cannot go on: no request waiting, or no room for a response
   always_comb begin
      unique case (step.hold_on)
         HOLD_REQ: stall = !req_valid;
         HOLD_RSP: stall = !stat.rsp_free;
         default:  stall = 1'b0;
      endcase
   end

   // Evaluate the jump condition
   always_comb begin
      unique case (step.br_cond)
         BR_ALWAYS:   taken = 1'b1;
         BR_NEG:      taken = stat.neg;
         BR_DIRECT:   taken = stat.direct;
         BR_ZERO:     taken = stat.zero;
         BR_MORE:     taken = stat.more;
         BR_DIG_LEFT: taken = stat.dig_left;
         default:     taken = 1'b0;
      endcase
   end

   // Advance or jump
   always_comb begin
      pc_in = pc_ff;
      if (!stall) begin
         pc_in = taken ? step.target : pc_ff + PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign req_ready = (step.hold_on == HOLD_REQ);
   assign ctrl.step = step;
   assign ctrl.go   = !stall;

`ifndef SYNTH
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < PROG_LEN)
      else $error("step counter outside program");

   a_accept_prefix: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !stat.neg |=> pc_ff == ST_PREFIX)
      else $error("accepted request did not start with the prefix");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      step.hold_on == HOLD_RSP && !stat.rsp_free |=> $stable(pc_ff))
      else $error("step advanced while the response was blocked");
`endif

endmodule

// ===== sv/token_announce_track_sequencer_top.sv =====
// Top level of the token announce track sequencer.
// Instantiates tats_sequencer and tats_datapath; depends on tats_pkg and tats_ifs.
//
// Takes one signed token request at a time and returns its announcement as a list of
// tracks: prefix, then either one whole-number track, the zero digit, or the decimal
// digits most significant first, then the suffix marked last; a negative token gives no
// response. A microcoded sequencer runs the work: each decimal digit takes one multiply
// by the reciprocal and one correction step of the divide-by-ten unit, and each track
// is sent by its own step, held while the response register is full. direct_limit
// resets to 99; the user must write it only while no request is in flight, as the block
// itself does not enforce this. The register port is always ready.
module token_announce_track_sequencer_top import tats_pkg::*; #(
   parameter int MAX_DIGITS = 10
) (
   input logic clock,
   input logic reset,
   tats_req_if.sink   req_bus,
   tats_rsp_if.source rsp_bus,
   tats_csr_if.sink   csr_bus
);

   tats_ctrl_type ctrl;
   tats_stat_type stat;

   assign csr_bus.ready = 1'b1;

   // Step counter and microcode ROM
   tats_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .stat      (stat),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .ctrl      (ctrl)
   );

   // Value, digit stack and response register
   tats_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_token        (req_bus.token),
      .csr_valid        (csr_bus.valid),
      .csr_direct_limit (csr_bus.direct_limit),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_folder       (rsp_bus.folder),
      .rsp_track        (rsp_bus.track),
      .rsp_last         (rsp_bus.last)
   );

endmodule

// ===== verif/tb_token_announce_track_sequencer_top.sv =====
`timescale 1ns / 1ps
// Testbench for token_announce_track_sequencer_top: random and directed token requests,
// a track-list predictor and a response checker. Depends on tats_pkg and tats_ifs.
module tb_token_announce_track_sequencer_top;
   import tats_pkg::*;

   localparam int DIGIT_CAP    = 10;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_LEN     = 400;
   localparam int HOLD_AT      = 200;
   localparam int CYCLE_LIMIT  = 400000;

   typedef struct packed {
      logic [FOLDER_W-1:0] folder;
      logic [TRACK_W-1:0]  track;
      logic                last;
   } track_rec_type;

   logic clock;
   logic reset;

   tats_req_if req_bus ();
   tats_rsp_if rsp_bus ();
   tats_csr_if csr_bus ();

   token_announce_track_sequencer_top #(
      .MAX_DIGITS(DIGIT_CAP)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic signed [TOKEN_W-1:0] token_q[$];
   track_rec_type             track_exp_q[$];
   logic [LIMIT_W-1:0]        whole_limit;
   int                        mismatch_cnt;
   int                        rsp_count;
   int                        req_gap;
   int                        rsp_wait;
   int                        hold_cnt;
   bit                        hold_done;
   logic                      long_hold;
   bit                        pace_on;
   int                        cycle_count;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Append the track list that announces one token
   function automatic void predict_tracks(input logic signed [TOKEN_W-1:0] tok);
      logic [TOKEN_W-1:0] v;
      logic [3:0]         digs[DIGIT_CAP];
      int                 n;
      v = tok;
      n = 0;
      if (v[TOKEN_W-1]) return;
      track_exp_q.push_back('{FOLDER_FRAME, TRACK_PREFIX, 1'b0});
      if (v >= 1 && v <= {24'd0, whole_limit}) begin
         track_exp_q.push_back('{FOLDER_WHOLE, v[TRACK_W-1:0], 1'b0});
      end else if (v == 0) begin
         track_exp_q.push_back('{FOLDER_DIGIT, TRACK_ZERO, 1'b0});
      end else begin
         // collect digits least significant first, play most significant first
         while (v > 0 && n < DIGIT_CAP) begin
            digs[n] = 4'(v % 10);
            v = v / 10;
            n++;
         end
         for (int i = n - 1; i >= 0; i--)
            track_exp_q.push_back('{FOLDER_DIGIT, 8'(digs[i]) + 8'd1, 1'b0});
      end
      track_exp_q.push_back('{FOLDER_FRAME, TRACK_SUFFIX, 1'b1});
   endfunction

   // Draw one token: mostly well-formed values of every digit count, some negatives
   function automatic logic signed [TOKEN_W-1:0] pick_token();
      int unsigned     sel;
      int unsigned     nd;
      longint unsigned lo;
      longint unsigned hi;
      logic [TOKEN_W-1:0] v;
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         v = $urandom() | 32'h8000_0000;
      end else if (sel < 40) begin
         v = $urandom_range(0, 300);
      end else if (sel < 50) begin
         v = $urandom() & 32'h7FFF_FFFF;
      end else begin
         nd = $urandom_range(1, DIGIT_CAP);
         lo = 1;
         for (int i = 1; i < nd; i++) lo = lo * 10;
         hi = lo * 10 - 1;
         if (nd == 1) lo = 0;
         if (hi > 64'h7FFF_FFFF) hi = 64'h7FFF_FFFF;
         v = 32'(lo + ($urandom() % (hi - lo + 1)));
      end
      return v;
   endfunction

   // Request driver: present queued tokens, predict each accepted one
   always @(posedge clock) begin : req_driver
      logic                      nxt_valid;
      logic signed [TOKEN_W-1:0] nxt_token;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.token <= '0;
         req_gap = 0;
      end else begin
         nxt_valid = req_bus.valid;
         nxt_token = req_bus.token;
         if (req_bus.valid && req_bus.ready) begin
            predict_tracks(req_bus.token);
            void'(token_q.pop_front());
            nxt_valid = 1'b0;
            req_gap = pace_on ? $urandom_range(0, 3) : 0;
         end
         if (!nxt_valid && token_q.size() != 0) begin
            if (req_gap == 0) begin
               nxt_valid = 1'b1;
               nxt_token = token_q[0];
            end else begin
               req_gap--;
            end
         end
         req_bus.valid <= nxt_valid;
         req_bus.token <= nxt_token;
      end
   end

   // Long receiver hold-off, once, so the block backs up and stalls requests
   always @(posedge clock) begin
      if (reset) begin
         long_hold <= 1'b0;
         hold_cnt = 0;
         hold_done = 1'b0;
      end else if (!hold_done && !long_hold && rsp_count >= HOLD_AT) begin
         long_hold <= 1'b1;
         hold_cnt = HOLD_LEN;
      end else if (long_hold) begin
         if (hold_cnt == 0) begin
            long_hold <= 1'b0;
            hold_done = 1'b1;
         end else begin
            hold_cnt--;
         end
      end
   end

   // Response monitor: check each accepted track against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      logic          nxt_ready;
      track_rec_type got;
      track_rec_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         nxt_ready = rsp_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.folder, rsp_bus.track, rsp_bus.last};
            if (track_exp_q.size() == 0) begin
               if (mismatch_cnt < 10)
                  $display("%0t: unexpected track folder=%0d track=%0d last=%0d",
                           $realtime, got.folder, got.track, got.last);
               mismatch_cnt++;
            end else begin
               want = track_exp_q.pop_front();
               if (got.folder !== want.folder || got.track !== want.track ||
                   got.last !== want.last) begin
                  if (mismatch_cnt < 10)
                     $display("%0t: track mismatch exp folder=%0d track=%0d last=%0d, %s",
                              $realtime, want.folder, want.track, want.last,
                              $sformatf("got folder=%0d track=%0d last=%0d",
                                        got.folder, got.track, got.last));
                  mismatch_cnt++;
               end
            end
            rsp_count <= rsp_count + 1;
            rsp_wait = pace_on ? $urandom_range(0, 3) : 0;
         end
         if (rsp_wait > 0) begin
            nxt_ready = 1'b0;
            rsp_wait--;
         end else begin
            nxt_ready = !long_hold;
         end
         rsp_bus.ready <= nxt_ready;
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Write the direct limit register
   task automatic write_limit(input logic [LIMIT_W-1:0] val);
      @(posedge clock);
      csr_bus.valid        <= 1'b1;
      csr_bus.direct_limit <= val;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      whole_limit = val;
      csr_bus.valid <= 1'b0;
   endtask

   // Hold until every request is taken and every track has come back
   task automatic wait_drained();
      while (token_q.size() != 0 || req_bus.valid || track_exp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Queue random tokens; ignored negatives do not count
   task automatic queue_random(input int count);
      logic signed [TOKEN_W-1:0] tok;
      int                        n;
      n = 0;
      while (n < count) begin
         tok = pick_token();
         token_q.push_back(tok);
         if (!tok[TOKEN_W-1]) n++;
      end
   endtask

   // Stimulus sequence
   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.token        = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.direct_limit = '0;
      whole_limit          = LIMIT_RST;
      mismatch_cnt         = 0;
      rsp_count            = 0;
      pace_on              = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset limit: boundaries around the limit, digit counts, extremes, negatives
      token_q.push_back(32'sd0);
      token_q.push_back(32'sd1);
      token_q.push_back(32'sd98);
      token_q.push_back(32'sd99);
      token_q.push_back(32'sd100);
      token_q.push_back(32'sd101);
      token_q.push_back(32'sd9);
      token_q.push_back(32'sd10);
      token_q.push_back(32'sd255);
      token_q.push_back(32'sh7FFF_FFFF);
      token_q.push_back(-32'sd1);
      token_q.push_back(32'sh8000_0000);
      token_q.push_back(32'sd1000000000);
      token_q.push_back(32'sd999999999);
      token_q.push_back(32'sd1234567890);
      wait_drained();

      // Zero limit: nothing plays as a whole number, zero still as a digit
      write_limit(8'd0);
      token_q.push_back(32'sd0);
      token_q.push_back(32'sd1);
      token_q.push_back(32'sd7);
      queue_random(50);
      wait_drained();

      // Largest limit
      write_limit(8'd255);
      token_q.push_back(32'sd255);
      token_q.push_back(32'sd256);
      token_q.push_back(32'sd254);
      token_q.push_back(32'sd0);
      queue_random(50);
      wait_drained();

      // Back-to-back stretch with no idling on either side
      write_limit(8'd1);
      pace_on = 1'b0;
      queue_random(50);
      wait_drained();
      pace_on = 1'b1;

      write_limit(8'($urandom_range(2, 254)));
      queue_random(70);
      wait_drained();

      write_limit(8'd9);
      pace_on = 1'b0;
      queue_random(50);
      wait_drained();
      pace_on = 1'b1;

      write_limit(LIMIT_RST);
      queue_random(70);
      wait_drained();

      mismatch_cnt += track_exp_q.size();
      if (mismatch_cnt == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
